[rtl/core/pirb_pkg.sv]
// Package with the shared types, constants and the CORDIC arctangent table.
package pirb_pkg;

  localparam int TAB_LEN = 24;
  localparam int HALF_PI_Q12 = 6434;
  localparam int PI_Q12 = 12868;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic [7:0]         box_slot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [22:0]        extent_x;
    logic [22:0]        extent_y;
    logic [22:0]        extent_z;
    logic signed [14:0] yaw;
  } item_t;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [22:0]        sx;
    logic [22:0]        sy;
    logic [22:0]        sz;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } box_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } back_state_t;

  function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      5'd10: v = 34'sd262144;
      5'd11: v = 34'sd131072;
      5'd12: v = 34'sd65536;
      5'd13: v = 34'sd32768;
      5'd14: v = 34'sd16384;
      5'd15: v = 34'sd8192;
      5'd16: v = 34'sd4096;
      5'd17: v = 34'sd2048;
      5'd18: v = 34'sd1024;
      5'd19: v = 34'sd512;
      5'd20: v = 34'sd256;
      5'd21: v = 34'sd128;
      5'd22: v = 34'sd64;
      5'd23: v = 34'sd32;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Rounds a Q3.30 value to Q1.14, saturates to plus or minus one and applies the flip.
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v, input logic flip);
    logic signed [33:0] t;
    logic signed [17:0] r;
    logic signed [15:0] s;
    t = (v + 34'sd32768) >>> 16;
    r = t[17:0];
    if (r > 18'sd16384) begin
      s = 16'sd16384;
    end else if (r < -18'sd16384) begin
      s = -16'sd16384;
    end else begin
      s = r[15:0];
    end
    return flip ? -s : s;
  endfunction

endpackage

[rtl/core/point_in_rotated_box_search_core.sv]
// Top level: box store point search with input queue, back end and config register.
// A load runs the CORDIC on the yaw and writes the box to the store when the CORDIC is done.
// A query reads one box per cycle from the store RAM, up to min(box_count, MAX_BOXES) boxes,
// and stops reading early when a box matches. One item is worked on at a time.
// A two-word input queue and a one-word result register decouple both sides.
// Synchronous active-low reset clears the control state and box_count; the store is not cleared.
module point_in_rotated_box_search_core #(
  parameter int MAX_BOXES = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic [7:0]         in_box_slot,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [22:0]        in_extent_x,
  input  logic [22:0]        in_extent_y,
  input  logic [22:0]        in_extent_z,
  input  logic signed [14:0] in_yaw,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [8:0]  out_hit_box,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_box_count
);
  import pirb_pkg::*;

  item_t      in_item, q_item;
  logic       q_valid, q_pop;
  logic [8:0] box_count_r;

  always_comb begin
    in_item.func     = in_func;
    in_item.box_slot = in_box_slot;
    in_item.pos_x    = in_pos_x;
    in_item.pos_y    = in_pos_y;
    in_item.pos_z    = in_pos_z;
    in_item.extent_x = in_extent_x;
    in_item.extent_y = in_extent_y;
    in_item.extent_z = in_extent_z;
    in_item.yaw      = in_yaw;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      box_count_r <= cfg_box_count;
    end
  end

  pirb_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_item)
  );

  pirb_back #(.MAX_BOXES(MAX_BOXES), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (q_valid),
    .item        (q_item),
    .item_pop    (q_pop),
    .box_count   (box_count_r),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_hit_box (out_hit_box)
  );
endmodule

[rtl/core/pirb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pirb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/pirb_fifo.sv]
// Two-word queue between the accepting front and the executing back.
module pirb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pirb_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pirb_pkg::item_t rdata
);
  import pirb_pkg::*;

  item_t      mem_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wptr_r != rptr_r))
    else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not follow a write");
`endif
endmodule

[rtl/core/pirb_cordic.sv]
// Iterative rotation-mode CORDIC giving cos and sin of minus the yaw.
module pirb_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [14:0] yaw,
  output logic               busy,
  output logic               done,
  output logic signed [15:0] cos_q14,
  output logic signed [15:0] sin_q14
);
  import pirb_pkg::*;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt, flip_r, flip_nxt;
  logic signed [16:0] a;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    a        = -17'(yaw);
    if (start) begin
      flip_nxt = 1'b0;
      if (a > 17'sd6434) begin
        a        = a - 17'(PI_Q12);
        flip_nxt = 1'b1;
      end else if (a < -17'sd6434) begin
        a        = a + 17'(PI_Q12);
        flip_nxt = 1'b1;
      end
      x_nxt    = GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = 34'(a) <<< 16;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - atan_q28(i_r);
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + atan_q28(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    i_r    <= i_nxt;
    flip_r <= flip_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign cos_q14 = to_q14(x_r, flip_r);
  assign sin_q14 = to_q14(y_r, flip_r);
endmodule

[rtl/core/pirb_back.sv]
// Back end: stores loaded boxes and scans the box store for each query.
module pirb_back #(
  parameter int MAX_BOXES = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  pirb_pkg::item_t    item,
  output logic               item_pop,
  input  logic [8:0]         box_count,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [8:0]  out_hit_box
);
  import pirb_pkg::*;

  localparam int AW = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  back_state_t state_r, state_nxt;
  item_t       item_r;
  logic [CW-1:0] n_r, n_nxt, iss_r, iss_nxt;
  logic        found_r, found_nxt;
  logic [AW-1:0] hit_r, hit_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic signed [8:0] res_r, res_nxt;

  logic        cor_start, cor_busy, cor_done;
  logic signed [15:0] cor_cos, cor_sin;
  logic        ram_we, ram_re;
  box_t        wbox, rbox;
  logic        slot_ok, issuing, pipe_busy;

  // Scan pipeline: read, centre offsets, products, range test.
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] k1_r, k2_r, k3_r, k4_r;
  logic signed [24:0] sx2_r, sy2_r, dz2_r;
  logic signed [15:0] cs2_r, sn2_r;
  logic [22:0] ex2_r, ey2_r, ez2_r, ex3_r, ey3_r;
  logic signed [40:0] pxc3_r, pys3_r, pxs3_r, pyc3_r;
  logic        inz3_r, m4_r;
  logic signed [24:0] adz;
  logic signed [41:0] lx, ly, limx, limy;

  assign slot_ok  = (32'(item.box_slot) < MAX_BOXES);
  assign item_pop = (state_r == ST_IDLE) && item_valid;
  assign cor_start = item_pop && (item.func == FUNC_LOAD) && slot_ok;
  assign ram_we   = (state_r == ST_LOAD) && cor_done;
  assign issuing  = (state_r == ST_SCAN) && (iss_r < n_r) && !found_r;
  assign ram_re   = issuing;
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;

  always_comb begin
    wbox.cx = item_r.pos_x;
    wbox.cy = item_r.pos_y;
    wbox.cz = item_r.pos_z;
    wbox.sx = item_r.extent_x;
    wbox.sy = item_r.extent_y;
    wbox.sz = item_r.extent_z;
    wbox.cs = cor_cos;
    wbox.sn = cor_sin;
  end

  pirb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .yaw     (item.yaw),
    .busy    (cor_busy),
    .done    (cor_done),
    .cos_q14 (cor_cos),
    .sin_q14 (cor_sin)
  );

  pirb_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item_r.box_slot)),
    .wdata (wbox),
    .re    (ram_re),
    .raddr (iss_r[AW-1:0]),
    .rdata (rbox)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    res_valid_nxt = res_valid_r && !out_pop;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (item_pop) begin
          if (item.func == FUNC_QUERY) begin
            state_nxt = ST_SCAN;
            iss_nxt   = '0;
            found_nxt = 1'b0;
            n_nxt     = (32'(box_count) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(box_count);
          end else if (slot_ok) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (cor_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (v4_r && m4_r && !found_r) begin
          found_nxt = 1'b1;
          hit_nxt   = k4_r;
        end
        if ((found_r || (!issuing && !pipe_busy)) && !res_valid_nxt) begin
          res_valid_nxt = 1'b1;
          res_nxt       = found_r ? 9'(hit_r) : -9'sd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= 1'b0;
      res_valid_r <= 1'b0;
      iss_r       <= '0;
      n_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      res_valid_r <= res_valid_nxt;
      iss_r       <= iss_nxt;
      n_r         <= n_nxt;
      v1_r        <= issuing;
      v2_r        <= v1_r && (state_r == ST_SCAN);
      v3_r        <= v2_r && (state_r == ST_SCAN);
      v4_r        <= v3_r && (state_r == ST_SCAN);
    end
  end

  always_comb begin
    adz  = dz2_r < 0 ? -dz2_r : dz2_r;
    lx   = 42'(pxc3_r) - 42'(pys3_r);
    ly   = 42'(pxs3_r) + 42'(pyc3_r);
    limx = $signed(42'({1'b0, ex3_r, 13'd0}));
    limy = $signed(42'({1'b0, ey3_r, 13'd0}));
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    res_r <= res_nxt;
    if (item_pop) begin
      item_r <= item;
    end
    k1_r   <= iss_r[AW-1:0];
    k2_r   <= k1_r;
    sx2_r  <= 25'(item_r.pos_x) - 25'(rbox.cx);
    sy2_r  <= 25'(item_r.pos_y) - 25'(rbox.cy);
    dz2_r  <= 25'(item_r.pos_z) - 25'(rbox.cz);
    cs2_r  <= rbox.cs;
    sn2_r  <= rbox.sn;
    ex2_r  <= rbox.sx;
    ey2_r  <= rbox.sy;
    ez2_r  <= rbox.sz;
    k3_r   <= k2_r;
    pxc3_r <= 41'(sx2_r) * 41'(cs2_r);
    pys3_r <= 41'(sy2_r) * 41'(sn2_r);
    pxs3_r <= 41'(sx2_r) * 41'(sn2_r);
    pyc3_r <= 41'(sy2_r) * 41'(cs2_r);
    inz3_r <= ({adz, 1'b0} <= {3'd0, ez2_r});
    ex3_r  <= ex2_r;
    ey3_r  <= ey2_r;
    k4_r   <= k3_r;
    m4_r   <= inz3_r && (lx <= limx) && (lx >= -limx) && (ly <= limy) && (ly >= -limy);
  end

  assign out_empty   = !res_valid_r;
  assign out_hit_box = res_r;

`ifndef SYNTHESIS
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r <= n_r))
    else $error("scan issued past the box count");
  a_cordic_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    cor_busy |-> (state_r == ST_LOAD))
    else $error("CORDIC running outside a load");
  a_write_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_LOAD))
    else $error("store written outside a load");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_pop) |=> (res_valid_r && $stable(res_r)))
    else $error("waiting result lost or changed");
`endif
endmodule
